// ===== hdl/bst_pkg.sv =====
`default_nettype none
package bst_pkg;

  // Store geometry
  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  // links and count also hold the value CAPACITY (the none marker / full)
  localparam int LINK_W     = $clog2(CAPACITY + 1);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(CAPACITY);

  // Operation codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef logic [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic       success;
    logic [1:0] status;
    logic [4:0] count;
    logic       empty_res;
  } res_t;

  // Low ELEM_WIDTH bits of the 32-bit input, zero-extended when wider
  function automatic elem_t to_elem(input logic [31:0] v);
    logic [ELEM_WIDTH+31:0] t;
    t = {{ELEM_WIDTH{1'b0}}, v};
    return t[ELEM_WIDTH-1:0];
  endfunction

  // Count field is 5 bits wide whatever the capacity
  function automatic logic [4:0] to_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] t;
    t = {5'd0, c};
    return t[4:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bst_slot_store.sv =====
`default_nettype none
// Slot value memory with registered read and the shared equality compare
module bst_slot_store (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [bst_pkg::IDX_W-1:0] wr_addr,
  input  wire bst_pkg::elem_t     wr_data,
  input  wire logic               rd_en,
  input  wire logic [bst_pkg::IDX_W-1:0] rd_addr,
  input  wire bst_pkg::elem_t     key,
  output logic                    hit
);
  import bst_pkg::*;

  elem_t mem [CAPACITY];
  elem_t rd_data;

  // one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // compare unit, shared by every slot of the scan
  assign hit = (rd_data == key);

endmodule
`default_nettype wire

// ===== hdl/bounded_set_table.sv =====
`default_nettype none
// Channel  | Ports              | Handshake
// ---------+--------------------+-------------------------------------------
// request  | start, busy, req   | beat taken at edge with start & !busy
// result   | done, res          | one-cycle strobe on done, cannot be held
//
// Each request scans all CAPACITY slots through one value-memory read port
// and one comparator, then decides in S_ACT; a successful add then links the
// new slot in S_LINK, and a successful remove unlinks it in S_UNL1 and S_UNL2.
// busy stays high from the accept edge until done; done and busy low coincide.
// rst (synchronous) empties the set; the value memory is not cleared.
module bounded_set_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bst_pkg::req_t req,
  output logic               busy,
  output logic               done,
  output bst_pkg::res_t      res
);
  import bst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_UNL1 = 3'd4;
  localparam logic [2:0] S_UNL2 = 3'd5;

  logic [2:0]        state;
  logic [1:0]        op;
  elem_t             key;
  logic [CNT_W-1:0]  scan_cnt;
  logic [IDX_W-1:0]  scan_idx;
  logic              rd_pend;
  logic              rd_used;
  logic [IDX_W-1:0]  rd_slot;
  logic              found;
  logic [IDX_W-1:0]  pos;
  logic              free_found;
  logic [IDX_W-1:0]  free_slot;
  logic [LINK_W-1:0] p_link;
  logic [LINK_W-1:0] n_link;

  logic [CAPACITY-1:0] used;
  logic [LINK_W-1:0]   prev_link [CAPACITY];
  logic [LINK_W-1:0]   next_link [CAPACITY];
  logic [LINK_W-1:0]   head_slot;
  logic [LINK_W-1:0]   tail_slot;
  logic [CNT_W-1:0]    held_count;

  logic scan_issue;
  logic hit;
  logic mem_wr;

  assign busy       = (state != S_IDLE);
  assign scan_idx   = scan_cnt[IDX_W-1:0];
  assign scan_issue = (state == S_SCAN) && (scan_cnt < CNT_W'(CAPACITY));
  assign mem_wr     = (state == S_ACT) && (op == MODE_ADD) && !found && free_found;

  bst_slot_store u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (free_slot),
    .wr_data (key),
    .rd_en   (scan_issue),
    .rd_addr (scan_idx),
    .key     (key),
    .hit     (hit)
  );

  // sequencer, list and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_pend    <= 1'b0;
      used       <= '0;
      head_slot  <= NONE_SLOT;
      tail_slot  <= NONE_SLOT;
      held_count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        prev_link[i] <= NONE_SLOT;
        next_link[i] <= NONE_SLOT;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op         <= req.mode;
            key        <= to_elem(req.elem_value);
            scan_cnt   <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            rd_pend    <= 1'b0;
            state      <= S_SCAN;
          end
        end

        // issue one slot read per cycle, check the previous one
        S_SCAN: begin
          rd_pend <= scan_issue;
          rd_slot <= scan_idx;
          rd_used <= used[scan_idx];
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            state <= S_ACT;
          end
          if (rd_pend) begin
            if (rd_used && hit && !found) begin
              found <= 1'b1;
              pos   <= rd_slot;
            end
            if (!rd_used && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_slot;
            end
          end
        end

        // decide on the scan outcome
        S_ACT: begin
          res.success   <= 1'b0;
          res.status    <= ST_ABSENT;
          res.count     <= to_count(held_count);
          res.empty_res <= (held_count == '0);
          state         <= S_IDLE;
          done          <= 1'b1;
          case (op)
            MODE_ADD: begin
              if (found) begin
                res.status <= ST_PRESENT;
              end else if (!free_found) begin
                res.status <= ST_FULL;
              end else begin
                used[free_slot]      <= 1'b1;
                prev_link[free_slot] <= tail_slot;
                next_link[free_slot] <= NONE_SLOT;
                done                 <= 1'b0;
                state                <= S_LINK;
              end
            end
            MODE_REMOVE: begin
              if (found) begin
                p_link <= prev_link[pos];
                n_link <= next_link[pos];
                done   <= 1'b0;
                state  <= S_UNL1;
              end
            end
            MODE_SEARCH: begin
              if (found) begin
                res.success <= 1'b1;
                res.status  <= ST_DONE;
              end
            end
            default: begin
            end
          endcase
        end

        // link new slot behind the old tail
        S_LINK: begin
          if (tail_slot != NONE_SLOT) begin
            next_link[tail_slot[IDX_W-1:0]] <= LINK_W'(free_slot);
          end else begin
            head_slot <= LINK_W'(free_slot);
          end
          tail_slot     <= LINK_W'(free_slot);
          held_count    <= held_count + 1'b1;
          res.success   <= 1'b1;
          res.status    <= ST_DONE;
          res.count     <= to_count(held_count + 1'b1);
          res.empty_res <= 1'b0;
          done          <= 1'b1;
          state         <= S_IDLE;
        end

        // bridge the neighbors around the removed slot
        S_UNL1: begin
          if (head_slot != LINK_W'(pos)) begin
            next_link[p_link[IDX_W-1:0]] <= n_link;
          end else begin
            head_slot <= n_link;
          end
          if (n_link != NONE_SLOT) begin
            prev_link[n_link[IDX_W-1:0]] <= p_link;
          end else begin
            tail_slot <= p_link;
          end
          state <= S_UNL2;
        end

        // free the removed slot
        S_UNL2: begin
          prev_link[pos] <= NONE_SLOT;
          next_link[pos] <= NONE_SLOT;
          used[pos]      <= 1'b0;
          held_count     <= held_count - 1'b1;
          res.success    <= 1'b1;
          res.status     <= ST_DONE;
          res.count      <= to_count(held_count - 1'b1);
          res.empty_res  <= (held_count == CNT_W'(1));
          done           <= 1'b1;
          state          <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
